>>> hdl/med_pkg.sv
// Shared types, constants and local edge tables for the mesh edge table.
// Used by med_ctrl, med_dp and mesh_edge_dedup_table.
`default_nettype none
package med_pkg;

  localparam int VID_W   = 13;
  localparam int NUM_W   = 14;
  localparam int LOC_W   = 4;
  localparam int MARK_W  = 3;
  localparam int STAT_W  = 2;
  localparam int ETYPE_W = 2;
  localparam int CIDX_W  = 2;

  localparam logic [ETYPE_W-1:0] ETYPE_TRI   = 2'd0;
  localparam logic [ETYPE_W-1:0] ETYPE_TET   = 2'd1;
  localparam logic [ETYPE_W-1:0] ETYPE_PRISM = 2'd2;
  localparam logic [ETYPE_W-1:0] ETYPE_NONE  = 2'd3;

  localparam logic [CIDX_W-1:0] REG_ELEMENT_TYPE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_VERTEX_COUNT = 2'd1;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_ID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  localparam logic signed [MARK_W-1:0] MARK_PLAIN = -3'sd1;
  localparam logic signed [MARK_W-1:0] MARK_HORIZ = 3'sd1;
  localparam logic signed [MARK_W-1:0] MARK_VERT  = 3'sd2;

  localparam logic [VID_W-1:0] VCOUNT_RESET = 13'd4096;

  // Vertex slot pairs {first, second}, one per local edge.
  localparam logic [5:0] TRI_PAIRS [9] = '{
    {3'd1, 3'd2}, {3'd2, 3'd0}, {3'd0, 3'd1}, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
  localparam logic [5:0] TET_PAIRS [9] = '{
    {3'd1, 3'd2}, {3'd0, 3'd2}, {3'd0, 3'd1}, {3'd1, 3'd3}, {3'd2, 3'd3}, {3'd0, 3'd3},
    6'd0, 6'd0, 6'd0};
  localparam logic [5:0] PRI_PAIRS [9] = '{
    {3'd0, 3'd3}, {3'd1, 3'd4}, {3'd2, 3'd5}, {3'd1, 3'd2}, {3'd2, 3'd0}, {3'd0, 3'd1},
    {3'd4, 3'd5}, {3'd5, 3'd3}, {3'd3, 3'd4}};

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PAIR, ST_HEAD, ST_WALK, ST_NEW, ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic pair;
    logic head;
    logic walk;
    logic append;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic type_ok;
    logic bad;
    logic link_zero;
    logic hit;
    logic next_zero;
    logic last;
  } sts_t;

  function automatic logic [5:0] edge_pair(input logic [ETYPE_W-1:0] etype,
                                           input logic [LOC_W-1:0] k);
    logic [5:0] p;
    p = 6'd0;
    if (k <= 4'd8) begin
      unique case (etype)
        ETYPE_TRI:   p = TRI_PAIRS[k];
        ETYPE_TET:   p = TET_PAIRS[k];
        default:     p = PRI_PAIRS[k];
      endcase
    end
    return p;
  endfunction

  function automatic logic signed [MARK_W-1:0] local_mark(input logic [ETYPE_W-1:0] etype,
                                                          input logic [LOC_W-1:0] k);
    logic signed [MARK_W-1:0] m;
    m = MARK_PLAIN;
    if (etype == ETYPE_PRISM) begin
      m = (k < 4'd3) ? MARK_VERT : MARK_HORIZ;
    end
    return m;
  endfunction

  function automatic logic [LOC_W-1:0] last_edge(input logic [ETYPE_W-1:0] etype);
    logic [LOC_W-1:0] l;
    unique case (etype)
      ETYPE_TRI: l = 4'd2;
      ETYPE_TET: l = 4'd5;
      default:   l = 4'd8;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

>>> hdl/mesh_edge_dedup_table.sv
// Mesh edge table: takes one element per input word (triangle, tetrahedron or
// prism, picked by element_type) and returns one result word per local edge, 3, 6
// or 9 of them, in local edge order with last set on the final one. Each edge is
// ordered low/high and looked up in the chain of known edges that share its low
// vertex; a miss appends a new edge and, for prisms, a vertical or horizontal
// class number, unless the table is full. After reset the block clears all
// MAX_VERTICES entries (4096 by default) of the chain head memory and takes no
// input word meanwhile; configuration writes are taken at any time. Per edge the
// work is a pair select and a head read, then one walk step per chain entry
// visited, an append on a miss, and the output handshake. The chain walk through
// the single edge memory read port sets the pace. An element type of 3 is
// consumed and gives no result word.
// Depends on med_pkg, med_ctrl and med_dp.
`default_nettype none
module mesh_edge_dedup_table #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 16384
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [med_pkg::CIDX_W-1:0]          cfg_index,
  input  wire logic [med_pkg::VID_W-1:0]           cfg_data,
  // element input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [med_pkg::VID_W-1:0]           in_vert_a,
  input  wire logic [med_pkg::VID_W-1:0]           in_vert_b,
  input  wire logic [med_pkg::VID_W-1:0]           in_vert_c,
  input  wire logic [med_pkg::VID_W-1:0]           in_vert_d,
  input  wire logic [med_pkg::VID_W-1:0]           in_vert_e,
  input  wire logic [med_pkg::VID_W-1:0]           in_vert_f,
  // edge result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [med_pkg::LOC_W-1:0]                out_local_edge,
  output logic [med_pkg::NUM_W-1:0]                out_edge_number,
  output logic                                     out_is_new,
  output logic [med_pkg::VID_W-1:0]                out_low_vertex,
  output logic [med_pkg::VID_W-1:0]                out_high_vertex,
  output logic signed [med_pkg::MARK_W-1:0]        out_marker,
  output logic [med_pkg::NUM_W-1:0]                out_class_number,
  output logic [med_pkg::STAT_W-1:0]               out_status,
  output logic                                     out_last
);

  logic [med_pkg::ETYPE_W-1:0] etype_r;
  logic [med_pkg::VID_W-1:0]   vcount_r;
  logic [med_pkg::VID_W-1:0]   vin [6];
  med_pkg::cmd_t               cmd;
  med_pkg::sts_t               sts;

  assign cfg_ready = 1'b1;
  assign vin[0] = in_vert_a;
  assign vin[1] = in_vert_b;
  assign vin[2] = in_vert_c;
  assign vin[3] = in_vert_d;
  assign vin[4] = in_vert_e;
  assign vin[5] = in_vert_f;

  // Hold configuration; indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etype_r  <= med_pkg::ETYPE_TRI;
      vcount_r <= med_pkg::VCOUNT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == med_pkg::REG_ELEMENT_TYPE) etype_r <= cfg_data[med_pkg::ETYPE_W-1:0];
      else if (cfg_index == med_pkg::REG_VERTEX_COUNT) vcount_r <= cfg_data;
    end
  end

  med_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  med_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .etype      (etype_r),
    .vcount     (vcount_r),
    .vin        (vin),
    .res_local  (out_local_edge),
    .res_num    (out_edge_number),
    .res_new    (out_is_new),
    .res_lo     (out_low_vertex),
    .res_hi     (out_high_vertex),
    .res_mark   (out_marker),
    .res_cls    (out_class_number),
    .res_status (out_status)
  );

  // The result register is loaded for the current edge, so last follows the edge index.
  assign out_last = sts.last;

endmodule
`default_nettype wire

>>> hdl/med_ctrl.sv
// Controller state machine for the mesh edge table.
// Depends on med_pkg; drives med_dp through cmd_t and reads sts_t.
`default_nettype none
module med_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output med_pkg::cmd_t      cmd,
  input  wire med_pkg::sts_t sts
);

  med_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= med_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      med_pkg::ST_CLEAR: if (sts.clr_done) state_nxt = med_pkg::ST_IDLE;
      med_pkg::ST_IDLE:  if (in_valid && sts.type_ok) state_nxt = med_pkg::ST_PAIR;
      med_pkg::ST_PAIR:  state_nxt = sts.bad ? med_pkg::ST_OUT : med_pkg::ST_HEAD;
      med_pkg::ST_HEAD:  state_nxt = sts.link_zero ? med_pkg::ST_NEW : med_pkg::ST_WALK;
      med_pkg::ST_WALK: begin
        priority if (sts.hit) state_nxt = med_pkg::ST_OUT;
        else if (sts.next_zero) state_nxt = med_pkg::ST_NEW;
        else state_nxt = med_pkg::ST_WALK;
      end
      med_pkg::ST_NEW:   state_nxt = med_pkg::ST_OUT;
      med_pkg::ST_OUT: begin
        if (out_ready) state_nxt = sts.last ? med_pkg::ST_IDLE : med_pkg::ST_PAIR;
      end
      default: state_nxt = med_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      med_pkg::ST_CLEAR: cmd.clear = 1'b1;
      med_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      med_pkg::ST_PAIR: cmd.pair   = 1'b1;
      med_pkg::ST_HEAD: cmd.head   = 1'b1;
      med_pkg::ST_WALK: cmd.walk   = 1'b1;
      med_pkg::ST_NEW:  cmd.append = 1'b1;
      med_pkg::ST_OUT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready && !sts.last;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/med_dp.sv
// Datapath of the mesh edge table: vertex registers, chain memories, counters
// and the result register. Depends on med_pkg; steered by med_ctrl.
`default_nettype none
module med_dp #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 16384
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire med_pkg::cmd_t                        cmd,
  output med_pkg::sts_t                             sts,
  input  wire logic [med_pkg::ETYPE_W-1:0]          etype,
  input  wire logic [med_pkg::VID_W-1:0]            vcount,
  input  wire logic [med_pkg::VID_W-1:0]            vin [6],
  output logic [med_pkg::LOC_W-1:0]                 res_local,
  output logic [med_pkg::NUM_W-1:0]                 res_num,
  output logic                                      res_new,
  output logic [med_pkg::VID_W-1:0]                 res_lo,
  output logic [med_pkg::VID_W-1:0]                 res_hi,
  output logic signed [med_pkg::MARK_W-1:0]         res_mark,
  output logic [med_pkg::NUM_W-1:0]                 res_cls,
  output logic [med_pkg::STAT_W-1:0]                res_status
);

  localparam int VI = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EI = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int LW = $clog2(MAX_EDGES + 1);

  logic [med_pkg::VID_W-1:0]    vert_r [6];
  logic [med_pkg::LOC_W-1:0]    k_r;
  logic [med_pkg::VID_W-1:0]    lo_r, hi_r;
  logic signed [med_pkg::MARK_W-1:0] mark_r;

  logic [LW-1:0] head_mem [MAX_VERTICES];
  logic [LW-1:0] head_q_r, head_link_r;
  logic [LW-1:0] next_mem [MAX_EDGES];
  logic [VI-1:0] high_mem [MAX_EDGES];
  logic [LW-1:0] cls_mem  [MAX_EDGES];
  logic [med_pkg::MARK_W-1:0] mark_mem [MAX_EDGES];
  logic [LW-1:0] next_q_r;
  logic [VI-1:0] high_q_r;
  logic [LW-1:0] cls_q_r;
  logic [med_pkg::MARK_W-1:0] mark_q_r;
  logic [EI-1:0] cur_idx_r;

  logic [VI-1:0] clr_cnt_r;
  logic [LW-1:0] edge_total_r, vert_total_r, horiz_total_r;

  logic [5:0]                   pr;
  logic [med_pkg::VID_W-1:0]    va, vb, lo_c, hi_c;
  logic                         lo_ok, hi_ok, full;
  logic signed [med_pkg::MARK_W-1:0] lmark;
  logic [LW-1:0]                link_c, new_cls;
  logic [EI-1:0]                er_addr;
  logic                         hw_en;
  logic [VI-1:0]                hw_addr;
  logic [LW-1:0]                hw_data;

  function automatic logic id_ok(input logic [med_pkg::VID_W-1:0] v,
                                 input logic [med_pkg::VID_W-1:0] vc);
    return (v != '0) && (v <= vc) && (32'(v) <= 32'(MAX_VERTICES));
  endfunction

  // Pair selection for the current local edge.
  always_comb begin
    pr    = med_pkg::edge_pair(etype, k_r);
    va    = vert_r[pr[5:3]];
    vb    = vert_r[pr[2:0]];
    lo_c  = (vb < va) ? vb : va;
    hi_c  = (vb < va) ? va : vb;
    lo_ok = id_ok(lo_c, vcount);
    hi_ok = id_ok(hi_c, vcount);
    lmark = med_pkg::local_mark(etype, k_r);
    full  = (edge_total_r == LW'(MAX_EDGES));
    link_c  = cmd.walk ? next_q_r : head_q_r;
    er_addr = EI'(link_c - 1'b1);
    if (etype != med_pkg::ETYPE_PRISM) begin
      new_cls = '0;
    end else if (mark_r == med_pkg::MARK_VERT) begin
      new_cls = vert_total_r;
    end else begin
      new_cls = horiz_total_r;
    end
    hw_en   = cmd.clear || (cmd.append && !full);
    hw_addr = cmd.clear ? clr_cnt_r : VI'(lo_r - 1'b1);
    hw_data = cmd.clear ? '0 : LW'(edge_total_r + 1'b1);
  end

  always_comb begin
    sts.clr_done  = (clr_cnt_r == VI'(MAX_VERTICES - 1));
    sts.type_ok   = (etype != med_pkg::ETYPE_NONE);
    sts.bad       = !(lo_ok && hi_ok);
    sts.link_zero = (head_q_r == '0);
    sts.hit       = (high_q_r == VI'(hi_r - 1'b1));
    sts.next_zero = (next_q_r == '0);
    sts.last      = (k_r == med_pkg::last_edge(etype));
  end

  // Chain head memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (hw_en) begin
      head_mem[hw_addr] <= hw_data;
    end
    head_q_r <= head_mem[VI'(lo_c - 1'b1)];
  end

  // Per-edge memories: read along the chain, written on append.
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      next_mem[edge_total_r[EI-1:0]] <= head_link_r;
      high_mem[edge_total_r[EI-1:0]] <= VI'(hi_r - 1'b1);
      cls_mem[edge_total_r[EI-1:0]]  <= new_cls;
      mark_mem[edge_total_r[EI-1:0]] <= mark_r;
    end
    next_q_r <= next_mem[er_addr];
    high_q_r <= high_mem[er_addr];
    cls_q_r  <= cls_mem[er_addr];
    mark_q_r <= mark_mem[er_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r     <= '0;
      edge_total_r  <= '0;
      vert_total_r  <= '0;
      horiz_total_r <= '0;
      k_r           <= '0;
    end else begin
      if (cmd.clear && !sts.clr_done) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.load) k_r <= '0;
      else if (cmd.advance) k_r <= k_r + 1'b1;
      if (cmd.append && !full) begin
        edge_total_r <= edge_total_r + 1'b1;
        if (etype == med_pkg::ETYPE_PRISM) begin
          if (mark_r == med_pkg::MARK_VERT) vert_total_r <= vert_total_r + 1'b1;
          else horiz_total_r <= horiz_total_r + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) vert_r <= vin;
    if (cmd.pair) begin
      lo_r   <= lo_c;
      hi_r   <= hi_c;
      mark_r <= lmark;
    end
    if (cmd.head) head_link_r <= head_q_r;
    if (cmd.head || cmd.walk) cur_idx_r <= er_addr;
    if (cmd.pair && sts.bad) begin
      res_local  <= k_r;
      res_num    <= '0;
      res_new    <= 1'b0;
      res_lo     <= lo_c;
      res_hi     <= hi_c;
      res_mark   <= lmark;
      res_cls    <= '0;
      res_status <= med_pkg::STAT_BAD_ID;
    end else if (cmd.walk && sts.hit) begin
      res_local  <= k_r;
      res_num    <= med_pkg::NUM_W'(cur_idx_r);
      res_new    <= 1'b0;
      res_lo     <= lo_r;
      res_hi     <= hi_r;
      res_mark   <= mark_q_r;
      res_cls    <= med_pkg::NUM_W'(cls_q_r);
      res_status <= med_pkg::STAT_OK;
    end else if (cmd.append) begin
      res_local  <= k_r;
      res_num    <= full ? '0 : med_pkg::NUM_W'(edge_total_r);
      res_new    <= !full;
      res_lo     <= lo_r;
      res_hi     <= hi_r;
      res_mark   <= mark_r;
      res_cls    <= full ? '0 : med_pkg::NUM_W'(new_cls);
      res_status <= full ? med_pkg::STAT_FULL : med_pkg::STAT_OK;
    end
  end

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for mesh_edge_dedup_table: drives mesh elements under
// several element-type / vertex-count settings and checks every edge result word.
// Depends on med_pkg and the mesh_edge_dedup_table RTL only.
module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int VTX_LIMIT   = 4096;
  localparam int EDGE_LIMIT  = 16384;

  typedef logic [med_pkg::VID_W-1:0] vset_t [6];

  typedef struct packed {
    logic [med_pkg::LOC_W-1:0]         loc;
    logic [med_pkg::NUM_W-1:0]         num;
    logic                              is_new;
    logic [med_pkg::VID_W-1:0]         lo;
    logic [med_pkg::VID_W-1:0]         hi;
    logic signed [med_pkg::MARK_W-1:0] mark;
    logic [med_pkg::NUM_W-1:0]         cls;
    logic [med_pkg::STAT_W-1:0]        stat;
    logic                              last;
  } edge_word_t;

  // Edge table mirror plus the queue of expected edge words.
  class edge_scoreboard;
    bit [14:0]                  head_link [VTX_LIMIT];
    bit [14:0]                  next_link [EDGE_LIMIT];
    bit [11:0]                  high_m1   [EDGE_LIMIT];
    bit [med_pkg::NUM_W-1:0]    cls_tab   [EDGE_LIMIT];
    bit [med_pkg::MARK_W-1:0]   mark_tab  [EDGE_LIMIT];
    int                         edge_count, vert_count, horiz_count;
    logic [med_pkg::ETYPE_W-1:0] etype = med_pkg::ETYPE_TRI;
    logic [med_pkg::VID_W-1:0]   vcount = med_pkg::VCOUNT_RESET;
    edge_word_t                 expected_q [$];
    int                         mismatches, words_seen, elements, bad_words;

    function bit id_ok(logic [med_pkg::VID_W-1:0] v);
      return v >= 1 && v <= vcount && v <= VTX_LIMIT;
    endfunction

    // Predict the edge words of one accepted element and update the mirror.
    function void note_element(vset_t v);
      int ne, e, link;
      logic [5:0] p;
      logic [med_pkg::VID_W-1:0] lo, hi, t;
      edge_word_t w;
      bit found;
      if (etype == med_pkg::ETYPE_NONE) return;
      elements++;
      ne = (etype == med_pkg::ETYPE_TRI) ? 3 : (etype == med_pkg::ETYPE_TET) ? 6 : 9;
      for (int k = 0; k < ne; k++) begin
        p = (etype == med_pkg::ETYPE_TRI) ? med_pkg::TRI_PAIRS[k] :
            (etype == med_pkg::ETYPE_TET) ? med_pkg::TET_PAIRS[k] : med_pkg::PRI_PAIRS[k];
        lo = v[p[5:3]];
        hi = v[p[2:0]];
        if (hi < lo) begin
          t = lo; lo = hi; hi = t;
        end
        w = '0;
        w.loc = k[med_pkg::LOC_W-1:0];
        w.lo = lo;
        w.hi = hi;
        w.mark = (etype != med_pkg::ETYPE_PRISM) ? med_pkg::MARK_PLAIN :
                 (k < 3) ? med_pkg::MARK_VERT : med_pkg::MARK_HORIZ;
        w.stat = med_pkg::STAT_OK;
        w.last = (k == ne - 1);
        if (!id_ok(lo) || !id_ok(hi)) begin
          w.stat = med_pkg::STAT_BAD_ID;
        end else begin
          found = 0;
          link = head_link[lo - 1];
          while (link != 0 && link <= edge_count) begin
            e = link - 1;
            if (high_m1[e] == hi - 1) begin
              found = 1;
              w.num = e[med_pkg::NUM_W-1:0];
              w.cls = cls_tab[e];
              w.mark = mark_tab[e];
              break;
            end
            if (next_link[e] >= link) break;
            link = next_link[e];
          end
          if (!found) begin
            if (edge_count >= EDGE_LIMIT) begin
              w.stat = med_pkg::STAT_FULL;
            end else begin
              e = edge_count;
              if (etype == med_pkg::ETYPE_PRISM) begin
                if (w.mark == med_pkg::MARK_VERT) w.cls = vert_count++;
                else w.cls = horiz_count++;
              end
              high_m1[e] = hi - 1;
              cls_tab[e] = w.cls;
              mark_tab[e] = w.mark;
              next_link[e] = head_link[lo - 1];
              head_link[lo - 1] = e + 1;
              edge_count = e + 1;
              w.num = e[med_pkg::NUM_W-1:0];
              w.is_new = 1;
            end
          end
        end
        expected_q.push_back(w);
      end
    endfunction

    // Compare one accepted edge word with the oldest expectation.
    function void check_result(edge_word_t got);
      edge_word_t want;
      words_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected edge word %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.stat != med_pkg::STAT_OK) bad_words++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("edge word mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic [med_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [med_pkg::VID_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic [med_pkg::VID_W-1:0] in_vert_a = '0, in_vert_b = '0, in_vert_c = '0;
  logic [med_pkg::VID_W-1:0] in_vert_d = '0, in_vert_e = '0, in_vert_f = '0;
  logic out_ready = 0;
  wire cfg_ready, in_ready, out_valid, out_is_new, out_last;
  wire [med_pkg::LOC_W-1:0] out_local_edge;
  wire [med_pkg::NUM_W-1:0] out_edge_number, out_class_number;
  wire [med_pkg::VID_W-1:0] out_low_vertex, out_high_vertex;
  wire signed [med_pkg::MARK_W-1:0] out_marker;
  wire [med_pkg::STAT_W-1:0] out_status;

  edge_scoreboard sb = new();
  bit quiet = 0;       // no idling on either side in the last phase
  int cycles = 0;
  int stall_left = 0;

  mesh_edge_dedup_table dut (.*);

  always #6 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, sb.expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: stall in random bursts, take a word whenever valid and ready meet.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{out_local_edge, out_edge_number, out_is_new, out_low_vertex,
                        out_high_vertex, out_marker, out_class_number, out_status,
                        out_last});
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // Write both registers back to back; hold valid until each word is taken.
  task automatic set_mode(input logic [med_pkg::ETYPE_W-1:0] et,
                          input logic [med_pkg::VID_W-1:0] vc);
    cfg_valid <= 1;
    cfg_index <= med_pkg::REG_ELEMENT_TYPE;
    cfg_data  <= {{(med_pkg::VID_W-med_pkg::ETYPE_W){1'b0}}, et};
    do @(posedge clk); while (!cfg_ready);
    sb.etype = et;
    cfg_index <= med_pkg::REG_VERTEX_COUNT;
    cfg_data  <= vc;
    do @(posedge clk); while (!cfg_ready);
    sb.vcount = vc;
    cfg_valid <= 0;
  endtask

  // Send one element word, with an optional idle burst ahead of it.
  task automatic send_element(input vset_t v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid  <= 1;
    in_vert_a <= v[0];
    in_vert_b <= v[1];
    in_vert_c <= v[2];
    in_vert_d <= v[3];
    in_vert_e <= v[4];
    in_vert_f <= v[5];
    do @(posedge clk); while (!in_ready);
    sb.note_element(v);
  endtask

  // Drop valid, wait out every expected word, then cover a possible silent element.
  task automatic drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Mostly ids from a small window so edges repeat and chains grow; some noise.
  function automatic vset_t make_element(int vc);
    vset_t v;
    int span, base;
    span = (vc > VTX_LIMIT) ? VTX_LIMIT : (vc < 1) ? 1 : vc;
    base = (span > 16) ? $urandom_range(1, span - 15) : 1;
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(0, 11) == 0) v[i] = $urandom_range(0, 8191);
      else v[i] = base + $urandom_range(0, (span > 16) ? 15 : span - 1);
    end
    return v;
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 4))
      0: return 3;
      1: return VTX_LIMIT;
      2: return $urandom_range(3, VTX_LIMIT);
      3: return $urandom_range(VTX_LIMIT + 1, 8191);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  initial begin
    int vc;
    logic [med_pkg::ETYPE_W-1:0] et;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // Directed: extreme ids, repeated edges, bad ids, every element type.
    set_mode(med_pkg::ETYPE_TRI, med_pkg::VCOUNT_RESET);
    send_element('{1, 2, 3, 0, 0, 0});
    send_element('{4096, 1, 2, 8191, 8191, 8191});
    send_element('{3, 2, 1, 0, 0, 0});
    send_element('{0, 5, 6, 0, 0, 0});
    send_element('{8191, 7, 4096, 0, 0, 0});
    send_element('{4095, 4096, 2048, 0, 0, 0});
    drain();
    set_mode(med_pkg::ETYPE_PRISM, med_pkg::VCOUNT_RESET);
    send_element('{1, 2, 3, 4, 5, 6});
    send_element('{4, 5, 6, 7, 8, 9});
    send_element('{1, 2, 3, 4, 5, 6});
    drain();
    set_mode(med_pkg::ETYPE_TET, med_pkg::VCOUNT_RESET);
    send_element('{1, 2, 3, 4, 0, 0});
    send_element('{10, 11, 12, 13, 0, 0});
    drain();
    set_mode(med_pkg::ETYPE_NONE, med_pkg::VCOUNT_RESET);
    send_element('{1, 2, 3, 4, 5, 6});
    drain();
    set_mode(med_pkg::ETYPE_TRI, 13'd3);
    send_element('{1, 2, 3, 0, 0, 0});
    send_element('{1, 2, 4, 0, 0, 0});
    send_element('{3, 3, 3, 0, 0, 0});
    drain();
    set_mode(med_pkg::ETYPE_PRISM, 13'd8191);
    send_element('{4096, 4097, 1, 2, 3, 5});
    drain();

    // Random phases; the last one runs prisms with no idling.
    for (int ph = 0; ph < 7; ph++) begin
      et = (ph == 6) ? med_pkg::ETYPE_PRISM : (ph == 3) ? med_pkg::ETYPE_NONE :
           $urandom_range(0, 2);
      vc = (ph == 6) ? VTX_LIMIT : pick_count();
      quiet = (ph == 6);
      set_mode(et, vc[med_pkg::VID_W-1:0]);
      for (int n = 0; n < ((ph == 3) ? 5 : 36); n++) send_element(make_element(vc));
      drain();
    end

    $display("covered %0d elements, %0d edge words (%0d with error status), %0d edges stored",
             sb.elements, sb.words_seen, sb.bad_words, sb.edge_count);
    $display("%0d mismatches, %0d expected words left over",
             sb.mismatches, sb.expected_q.size());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/med_pkg.sv
hdl/med_ctrl.sv
hdl/med_dp.sv
hdl/mesh_edge_dedup_table.sv
test/testbench.sv
